FILE: rtl/brmv_pkg.sv
// Package for the binned running mean and variance block.
// Holds widths, status and mode codes, and the controller state type. No dependencies.
`timescale 1ns / 1ps

package brmv_pkg;

    localparam int NumBins  = 256;
    localparam int BinW     = 8;
    localparam int CfgW     = 9;
    localparam int CountW   = 24;
    localparam int MeanW    = 32;
    localparam int SumW     = 48;
    localparam int FracBits = 16;

    localparam logic [1:0] MODE_ADD      = 2'd0;
    localparam logic [1:0] MODE_READ     = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;
    localparam logic [1:0] MODE_READ_ALT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    typedef enum logic [3:0] {
        t_S_INIT, t_S_IDLE, t_S_READ, t_S_DIVM, t_S_MUL, t_S_ACC,
        t_S_VSTART, t_S_DIVV, t_S_OUT
    } t_state;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [MeanW-1:0]  mean;
        logic [SumW-1:0]   sum;
    } t_bin;

endpackage

FILE: rtl/brmv_divider.sv
// Restoring radix-2 divider, one quotient bit a cycle, 48-bit dividend, 24-bit divisor.
// Uses brmv_pkg for widths.
`timescale 1ns / 1ps

module brmv_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [brmv_pkg::SumW-1:0]         i_dividend,
    input  logic [brmv_pkg::CountW-1:0]       i_divisor,
    output logic                              o_done,
    output logic [brmv_pkg::SumW-1:0]         o_quotient
);

    logic [brmv_pkg::SumW-1:0]   r_quo, n_quo;
    logic [brmv_pkg::CountW:0]   r_rem, n_rem;
    logic [brmv_pkg::CountW-1:0] r_den;
    logic [5:0]                  r_cnt, n_cnt;
    logic                        r_busy, n_busy, r_done, n_done;
    logic [brmv_pkg::CountW+1:0] w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[brmv_pkg::SumW-1]} - {2'b00, r_den};
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = 6'(brmv_pkg::SumW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[brmv_pkg::CountW+1]) begin
                n_rem = w_trial[brmv_pkg::CountW:0];
                n_quo = {r_quo[brmv_pkg::SumW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[brmv_pkg::CountW-1:0], r_quo[brmv_pkg::SumW-1]};
                n_quo = {r_quo[brmv_pkg::SumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/brmv_bin_ram.sv
// Bin statistics memory: one write port, one read port with registered data.
// Uses brmv_pkg for the entry type.
`timescale 1ns / 1ps

module brmv_bin_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [brmv_pkg::BinW-1:0]     i_waddr,
    input  brmv_pkg::t_bin                i_wdata,
    input  logic [brmv_pkg::BinW-1:0]     i_raddr,
    output brmv_pkg::t_bin                o_rdata
);

    brmv_pkg::t_bin r_mem [brmv_pkg::NumBins];
    brmv_pkg::t_bin r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/binned_running_mean_variance.sv
// Top level of the binned running mean and variance block.
// Instantiates brmv_bin_ram and brmv_divider; uses brmv_pkg.
`timescale 1ns / 1ps
//
// One input beat carries a mode, a Q16.16 sample and a bin index; each input beat
// produces exactly one output beat with status, count, mean and sample variance.
// Mode 0 adds the sample to the bin with a Welford update, mode 1 (and 3) reads the
// bin, mode 2 clears every bin. Bins at or above bins_in_use are flagged and ignored.
// Items are handled one at a time. An add runs a 48-step mean division, a multiply,
// and a 48-step variance division, all on one shared bit-serial divider; an add to a
// saturated bin skips the mean division and the multiply. A read runs only the
// variance division; an out-of-range item goes straight to the output. A clear's
// result is registered when it is accepted, and it then sweeps the memory with input ready low.
// After reset the block sweeps the bin memory with input ready low; configuration
// writes are taken at any time. The result sits in an output register; while the
// receiver stalls it holds, and the next input beat is accepted only after that
// result is taken.
//
module binned_running_mean_variance (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [brmv_pkg::CfgW-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_mode,
    input  logic signed [brmv_pkg::MeanW-1:0] i_sample,
    input  logic [brmv_pkg::BinW-1:0]         i_bin_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_status,
    output logic [brmv_pkg::CountW-1:0]       o_sample_count,
    output logic signed [brmv_pkg::MeanW-1:0] o_running_mean,
    output logic [brmv_pkg::SumW-1:0]         o_sample_variance
);

    brmv_pkg::t_state r_state, n_state;
    logic [brmv_pkg::CfgW-1:0]   r_cfg;
    logic [brmv_pkg::BinW:0]     r_wipe;
    logic [brmv_pkg::BinW-1:0]   r_bin;
    logic [1:0]                  r_mode;
    logic signed [33:0]          r_x;
    logic signed [33:0]          r_oldm, r_newm;
    logic [brmv_pkg::CountW-1:0] r_cnt;
    logic [brmv_pkg::SumW-1:0]   r_sum;
    logic [63:0]                 r_prod;
    logic [1:0]                  r_ostat;
    logic                        r_ovalid;
    logic [brmv_pkg::CountW-1:0] r_ocnt;
    logic [brmv_pkg::MeanW-1:0]  r_omean;
    logic [brmv_pkg::SumW-1:0]   r_ovar;

    brmv_pkg::t_bin              w_rd, w_wdata;
    logic                        w_we;
    logic [brmv_pkg::BinW-1:0]   w_waddr;
    logic                        w_accept, w_oor;
    logic                        w_dstart, w_ddone;
    logic [brmv_pkg::SumW-1:0]   w_dnum, w_quo;
    logic [brmv_pkg::CountW-1:0] w_dden;
    logic [brmv_pkg::CountW-1:0] w_n;
    logic [33:0]                 w_diff, w_absd, w_absa, w_absb;
    logic signed [33:0]          w_step;
    logic [brmv_pkg::SumW:0]     w_acc;
    logic [brmv_pkg::SumW-1:0]   w_add;

    assign w_accept = i_valid && o_ready;
    assign w_oor    = ({1'b0, i_bin_index} >= r_cfg);
    assign w_n      = r_cnt + 24'd1;
    assign w_diff   = r_x - r_oldm;
    assign w_absd   = w_diff[33] ? (-w_diff) : w_diff;
    assign w_step   = w_diff[33] ? -$signed({1'b0, w_quo[32:0]})
                                 : $signed({1'b0, w_quo[32:0]});
    assign w_absa   = w_absd;
    assign w_absb   = (r_x >= r_newm) ? 34'(r_x - r_newm) : 34'(r_newm - r_x);
    assign w_add    = r_prod[63:brmv_pkg::FracBits];
    assign w_acc    = {1'b0, r_sum} + {1'b0, w_add};

    brmv_bin_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_accept ? i_bin_index : r_bin),
        .o_rdata (w_rd)
    );

    brmv_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dnum),
        .i_divisor  (w_dden),
        .o_done     (w_ddone),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            brmv_pkg::t_S_INIT: begin
                if (r_wipe[brmv_pkg::BinW]) begin
                    n_state = brmv_pkg::t_S_IDLE;
                end
            end
            brmv_pkg::t_S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == brmv_pkg::MODE_CLEAR) begin
                        n_state = brmv_pkg::t_S_INIT;
                    end else if (w_oor) begin
                        n_state = brmv_pkg::t_S_OUT;
                    end else begin
                        n_state = brmv_pkg::t_S_READ;
                    end
                end
            end
            brmv_pkg::t_S_READ: begin
                if (r_mode == brmv_pkg::MODE_ADD && w_rd.count != '1) begin
                    n_state = brmv_pkg::t_S_DIVM;
                end else begin
                    n_state = brmv_pkg::t_S_VSTART;
                end
            end
            brmv_pkg::t_S_DIVM:   if (w_ddone) n_state = brmv_pkg::t_S_MUL;
            brmv_pkg::t_S_MUL:    n_state = brmv_pkg::t_S_ACC;
            brmv_pkg::t_S_ACC:    n_state = brmv_pkg::t_S_VSTART;
            brmv_pkg::t_S_VSTART: n_state = brmv_pkg::t_S_DIVV;
            brmv_pkg::t_S_DIVV:   if (w_ddone) n_state = brmv_pkg::t_S_OUT;
            brmv_pkg::t_S_OUT:    if (!r_ovalid || i_ready) n_state = brmv_pkg::t_S_IDLE;
            default:              n_state = brmv_pkg::t_S_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = (r_state == brmv_pkg::t_S_IDLE) && !r_ovalid;
        w_we     = 1'b0;
        w_waddr  = r_bin;
        w_wdata  = '{count: r_cnt, mean: r_newm[31:0], sum: r_sum};
        w_dstart = 1'b0;
        w_dnum   = {14'd0, w_absd};
        w_dden   = w_n;
        case (r_state)
            brmv_pkg::t_S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_wipe[brmv_pkg::BinW-1:0];
                w_wdata = '0;
            end
            brmv_pkg::t_S_READ: begin
                w_dstart = (r_mode == brmv_pkg::MODE_ADD) && (w_rd.count != '1);
                w_dnum   = {14'd0, (r_x >= $signed({{2{w_rd.mean[31]}}, w_rd.mean}))
                            ? 34'(r_x - $signed({{2{w_rd.mean[31]}}, w_rd.mean}))
                            : 34'($signed({{2{w_rd.mean[31]}}, w_rd.mean}) - r_x)};
                w_dden   = w_rd.count + 24'd1;
            end
            brmv_pkg::t_S_ACC: begin
                w_we = 1'b1;
                w_wdata = '{count: r_cnt, mean: r_newm[31:0],
                            sum: w_acc[brmv_pkg::SumW] ? '1 : w_acc[brmv_pkg::SumW-1:0]};
            end
            brmv_pkg::t_S_VSTART: begin
                w_dstart = 1'b1;
                w_dnum   = r_sum;
                w_dden   = r_cnt - 24'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= brmv_pkg::t_S_INIT;
            r_wipe   <= '0;
            r_cfg    <= 9'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= (i_cfg_wdata > 9'(brmv_pkg::NumBins)) ? 9'(brmv_pkg::NumBins)
                                                               : i_cfg_wdata;
            end
            if (r_state == brmv_pkg::t_S_INIT) begin
                r_wipe <= r_wipe + 1'b1;
            end else begin
                r_wipe <= '0;
            end
            if ((w_accept && i_mode == brmv_pkg::MODE_CLEAR)
                || (r_state == brmv_pkg::t_S_OUT && (!r_ovalid || i_ready))) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_bin  <= i_bin_index;
            r_mode <= i_mode;
            r_x    <= 34'(i_sample);
            if (i_mode == brmv_pkg::MODE_CLEAR) begin
                r_ostat <= brmv_pkg::ST_CLEAR;
                r_ocnt  <= '0;
                r_omean <= '0;
                r_ovar  <= '0;
            end else if (w_oor) begin
                r_ostat <= brmv_pkg::ST_RANGE;
            end else begin
                r_ostat <= brmv_pkg::ST_OK;
            end
        end
        case (r_state)
            brmv_pkg::t_S_READ: begin
                r_cnt  <= w_rd.count;
                r_oldm <= 34'($signed(w_rd.mean));
                r_newm <= 34'($signed(w_rd.mean));
                r_sum  <= w_rd.sum;
                if (r_mode == brmv_pkg::MODE_ADD && w_rd.count == '1) begin
                    r_ostat <= brmv_pkg::ST_SAT;
                end
            end
            brmv_pkg::t_S_DIVM: begin
                if (w_ddone) begin
                    r_newm <= r_oldm + w_step;
                    r_cnt  <= w_n;
                end
            end
            brmv_pkg::t_S_MUL: begin
                r_prod <= w_absa[31:0] * w_absb[31:0]
                        + (w_absa[32] ? {w_absb[31:0], 32'd0} : 64'd0)
                        + (w_absb[32] ? {w_absa[31:0], 32'd0} : 64'd0);
            end
            brmv_pkg::t_S_ACC: begin
                r_sum <= w_acc[brmv_pkg::SumW] ? '1 : w_acc[brmv_pkg::SumW-1:0];
            end
            brmv_pkg::t_S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    if (r_ostat == brmv_pkg::ST_RANGE) begin
                        r_ocnt  <= '0;
                        r_omean <= '0;
                        r_ovar  <= '0;
                    end else begin
                        r_ocnt  <= r_cnt;
                        r_omean <= r_newm[31:0];
                        r_ovar  <= (r_cnt > 24'd1) ? w_quo : '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_ostat;
    assign o_sample_count    = r_ocnt;
    assign o_running_mean    = r_omean;
    assign o_sample_variance = r_ovar;

endmodule
